// ===== rtl/core/slt_pkg.sv =====
// Shared field widths, operation and status codes, and controller/datapath link types.
`default_nettype none

package slt_pkg;

  // Fixed widths of the request and response fields
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 7;

  // Request operation codes; codes above clear are no-ops
  localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 4'd1;
  localparam logic [FUNC_W-1:0] FN_READ       = 4'd2;
  localparam logic [FUNC_W-1:0] FN_LOCATE     = 4'd3;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd4;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Source of the working slot index
  typedef enum logic [1:0] {
    IDX_POS  = 2'd0,
    IDX_ZERO = 2'd1,
    IDX_CNT  = 2'd2,
    IDX_LAST = 2'd3
  } idx_sel_e;

  // One datapath action per cycle
  typedef enum logic [3:0] {
    DP_NONE      = 4'd0,
    DP_LOAD      = 4'd1,
    DP_SET_STAT  = 4'd2,
    DP_INIT_UP   = 4'd3,
    DP_INIT_TAKE = 4'd4,
    DP_INIT_LOC  = 4'd5,
    DP_UP_STEP   = 4'd6,
    DP_DN_STEP   = 4'd7,
    DP_LOC_STEP  = 4'd8,
    DP_TAKE_RD   = 4'd9,
    DP_CAPTURE   = 4'd10,
    DP_PLACE     = 4'd11,
    DP_DEC       = 4'd12,
    DP_FOUND     = 4'd13,
    DP_CLEAR     = 4'd14,
    DP_PUBLISH   = 4'd15
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    status_e  stat;
    idx_sel_e idx_sel;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_ok;
    logic              pos_ins_ok;
    logic              full;
    logic              empty;
    logic              up_more;
    logic              dn_more;
    logic              loc_more;
    logic              loc_hit;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/slt_in_if.sv =====
// Request channel: valid/ready handshake carrying one list operation.
`default_nettype none

interface slt_in_if import slt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/slt_out_if.sv =====
// Response channel: valid/ready handshake carrying one operation result.
`default_nettype none

interface slt_out_if import slt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] value_out;
  logic [POS_W-1:0]        found_position;
  logic [CNT_W-1:0]        count;

  modport source (output valid, status, value_out, found_position, count, input ready);
  modport sink   (input valid, status, value_out, found_position, count, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/sequential_list_table_core.sv =====
// Top level of the sequential list table: packed list of signed words with list operations.
//
// Requests arrive on req_i (func, position, value) and each produces exactly one
// response on rsp_o (status, value_out, found_position, count), in request order.
// A request is taken only while the controller is idle, so one operation runs at a time.
// Inserts, deletes, pushes, pops and locates take longer the more entries they move or
// compare; the longest is a delete or pop front on a full list, set by the walk over
// the entry memory: one entry read and one entry written per cycle.
// The response sits in an output register; the next request is accepted while it
// waits, and that request's result is held back until the register is taken.
// Reset empties the list (count zero) and drops any pending response; the
// entry memory itself is not cleared, since only filled positions are read.
`default_nettype none

module sequential_list_table_core import slt_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slt_in_if.sink     req_i,
  slt_out_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each request
  slt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the list and build the response
  slt_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (req_i.func),
    .position_i       (req_i.position),
    .value_i          (req_i.value),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .status_o         (rsp_o.status),
    .value_out_o      (rsp_o.value_out),
    .found_position_o (rsp_o.found_position),
    .count_o          (rsp_o.count)
  );

endmodule

`default_nettype wire

// ===== rtl/core/slt_ctrl.sv =====
// Controller state machine: sequences checks, shifts, searches and result transfer.
`default_nettype none

module slt_ctrl import slt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHECK    = 10'b00_0000_0010,
    S_SHIFT_UP = 10'b00_0000_0100,
    S_PLACE    = 10'b00_0000_1000,
    S_TAKE_RD  = 10'b00_0001_0000,
    S_CAPTURE  = 10'b00_0010_0000,
    S_SHIFT_DN = 10'b00_0100_0000,
    S_DEC      = 10'b00_1000_0000,
    S_LOCATE   = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath command
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '{op: DP_NONE, stat: ST_OK, idx_sel: IDX_POS};
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_FINISH;
        unique case (sts_i.func) inside
          FN_INSERT: begin
            if (!sts_i.pos_ins_ok) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_BAD_POS;
            end else if (sts_i.full) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_FULL;
            end else begin
              cmd_o.op      = DP_INIT_UP;
              cmd_o.idx_sel = IDX_POS;
              state_d       = S_SHIFT_UP;
            end
          end
          FN_DELETE, FN_READ: begin
            if (sts_i.empty) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_EMPTY;
            end else if (!sts_i.pos_ok) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_BAD_POS;
            end else begin
              cmd_o.op      = DP_INIT_TAKE;
              cmd_o.idx_sel = IDX_POS;
              state_d       = S_TAKE_RD;
            end
          end
          FN_LOCATE: begin
            cmd_o.op = DP_INIT_LOC;
            state_d  = S_LOCATE;
          end
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (sts_i.full) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_FULL;
            end else begin
              cmd_o.op      = DP_INIT_UP;
              cmd_o.idx_sel = (sts_i.func == FN_PUSH_FRONT) ? IDX_ZERO : IDX_CNT;
              state_d       = S_SHIFT_UP;
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (sts_i.empty) begin
              cmd_o.op   = DP_SET_STAT;
              cmd_o.stat = ST_EMPTY;
            end else begin
              cmd_o.op      = DP_INIT_TAKE;
              cmd_o.idx_sel = (sts_i.func == FN_POP_FRONT) ? IDX_ZERO : IDX_LAST;
              state_d       = S_TAKE_RD;
            end
          end
          FN_CLEAR: begin
            cmd_o.op = DP_CLEAR;
          end
          default: begin
            cmd_o.op = DP_NONE;
          end
        endcase
      end
      S_SHIFT_UP: begin
        // Move one entry up per cycle; the last pending write drains on exit
        if (sts_i.up_more) begin
          cmd_o.op = DP_UP_STEP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.op = DP_PLACE;
        state_d  = S_FINISH;
      end
      S_TAKE_RD: begin
        cmd_o.op = DP_TAKE_RD;
        state_d  = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd_o.op = DP_CAPTURE;
        state_d  = (sts_i.func == FN_READ) ? S_FINISH : S_SHIFT_DN;
      end
      S_SHIFT_DN: begin
        if (sts_i.dn_more) begin
          cmd_o.op = DP_DN_STEP;
        end else begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = DP_DEC;
        state_d  = S_FINISH;
      end
      S_LOCATE: begin
        // Compare the word read last cycle while fetching the next one
        if (sts_i.loc_hit) begin
          cmd_o.op = DP_FOUND;
          state_d  = S_FINISH;
        end else if (sts_i.loc_more) begin
          cmd_o.op = DP_LOC_STEP;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_PUBLISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/slt_dpath.sv =====
// Datapath: entry memory, fill count, walk pointer, working result and output register.
`default_nettype none

module slt_dpath import slt_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  output sts_t                         sts_o,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         rsp_valid_o,
  input  wire logic                    rsp_ready_i,
  output logic [STAT_W-1:0]            status_o,
  output logic signed [VAL_W-1:0]      value_out_o,
  output logic [POS_W-1:0]             found_position_o,
  output logic [CNT_W-1:0]             count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [WORD_WIDTH-1:0] entries_q [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic [WORD_WIDTH-1:0] w_q;
  logic [FUNC_W-1:0]     func_q;
  logic [POS_W-1:0]      pos_q;
  logic [CW-1:0]         idx_q;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         wr_addr_q;
  logic                  wr_pend_q, wr_pend_d;
  logic                  loc_pend_q, loc_pend_d;
  logic                  out_valid_q, out_valid_d;
  status_e               res_stat_q;
  logic [VAL_W-1:0]      res_val_q;
  logic [POS_W-1:0]      res_found_q;
  status_e               out_stat_q;
  logic [VAL_W-1:0]      out_val_q;
  logic [POS_W-1:0]      out_found_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic [PW-1:0]         pos_ext, cnt_ext, pos_m1;
  logic                  pos_nz;
  logic [CW-1:0]         ptr_m1, ptr_p1, cnt_m1, idx_new, rd_full;
  logic [AW-1:0]         rd_addr, mem_waddr;
  logic                  mem_we;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic                  out_free;

  // Position checks against the current length
  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(cnt_q);
  assign pos_m1  = pos_ext - PW'(1);
  assign pos_nz  = (pos_q != '0);
  assign ptr_m1  = ptr_q - CW'(1);
  assign ptr_p1  = ptr_q + CW'(1);
  assign cnt_m1  = cnt_q - CW'(1);

  always_comb begin
    case (cmd_i.idx_sel)
      IDX_POS:  idx_new = pos_m1[CW-1:0];
      IDX_ZERO: idx_new = '0;
      IDX_CNT:  idx_new = cnt_q;
      IDX_LAST: idx_new = cnt_m1;
      default:  idx_new = '0;
    endcase
  end

  // Read address for the current step
  always_comb begin
    case (cmd_i.op)
      DP_UP_STEP: rd_full = ptr_m1;
      DP_DN_STEP: rd_full = ptr_p1;
      DP_TAKE_RD: rd_full = idx_q;
      default:    rd_full = ptr_q;
    endcase
  end
  assign rd_addr = rd_full[AW-1:0];

  // Drain a pending shift write first, else place the new word
  assign mem_we    = wr_pend_q || (cmd_i.op == DP_PLACE);
  assign mem_waddr = wr_pend_q ? wr_addr_q : idx_q[AW-1:0];
  assign mem_wdata = wr_pend_q ? rdata_q : w_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entries_q[rd_addr];
  end

  assign out_free = !out_valid_q || rsp_ready_i;

  // Control register next values
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    wr_pend_d   = (cmd_i.op == DP_UP_STEP) || (cmd_i.op == DP_DN_STEP);
    loc_pend_d  = (cmd_i.op == DP_LOC_STEP);
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (cmd_i.op)
      DP_INIT_UP:   ptr_d = cnt_q;
      DP_INIT_TAKE: ptr_d = idx_new;
      DP_INIT_LOC:  ptr_d = '0;
      DP_UP_STEP:   ptr_d = ptr_m1;
      DP_DN_STEP:   ptr_d = ptr_p1;
      DP_LOC_STEP:  ptr_d = ptr_p1;
      DP_PLACE:     cnt_d = cnt_q + CW'(1);
      DP_DEC:       cnt_d = cnt_m1;
      DP_CLEAR:     cnt_d = '0;
      DP_PUBLISH:   out_valid_d = 1'b1;
      default:      cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      wr_pend_q   <= 1'b0;
      loc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      wr_pend_q   <= wr_pend_d;
      loc_pend_q  <= loc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture, working result and output payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        func_q      <= func_i;
        pos_q       <= position_i;
        w_q         <= WORD_WIDTH'(value_i);
        res_stat_q  <= ST_OK;
        res_val_q   <= '0;
        res_found_q <= '0;
      end
      DP_SET_STAT:  res_stat_q <= cmd_i.stat;
      DP_INIT_UP:   idx_q <= idx_new;
      DP_INIT_TAKE: idx_q <= idx_new;
      DP_INIT_LOC:  res_stat_q <= ST_NOT_FOUND;
      DP_UP_STEP:   wr_addr_q <= ptr_q[AW-1:0];
      DP_DN_STEP:   wr_addr_q <= ptr_q[AW-1:0];
      DP_CAPTURE:   res_val_q <= VAL_W'($signed(rdata_q));
      DP_FOUND: begin
        res_stat_q  <= ST_OK;
        res_found_q <= POS_W'(ptr_q);
      end
      DP_PUBLISH: begin
        out_stat_q  <= res_stat_q;
        out_val_q   <= res_val_q;
        out_found_q <= res_found_q;
        out_cnt_q   <= CNT_W'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  // Status towards the controller
  assign sts_o.func       = func_q;
  assign sts_o.pos_ok     = pos_nz && (pos_ext <= cnt_ext);
  assign sts_o.pos_ins_ok = pos_nz && (pos_ext <= (cnt_ext + PW'(1)));
  assign sts_o.full       = (cnt_q == CW'(CAPACITY));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.up_more    = (ptr_q > idx_q);
  assign sts_o.dn_more    = (ptr_p1 < cnt_q);
  assign sts_o.loc_more   = (ptr_q < cnt_q);
  assign sts_o.loc_hit    = loc_pend_q && (rdata_q == w_q);
  assign sts_o.out_free   = out_free;

  assign rsp_valid_o      = out_valid_q;
  assign status_o         = out_stat_q;
  assign value_out_o      = out_val_q;
  assign found_position_o = out_found_q;
  assign count_o          = out_cnt_q;

  // Fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // A result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_PUBLISH) |-> out_free)
    else $error("result overwrote an untaken transfer");

  // Placing a word never collides with a pending shift write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && (cmd_i.op == DP_PLACE)))
    else $error("write port conflict");

  // A placed word grows the list by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_PLACE) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("fill count did not advance on place");

endmodule

`default_nettype wire
